/* hw/rtl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, command codes and helpers for the character-LCD encoder.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int MAX_SHIFT  = 40;
   localparam int ResultCap  = 40;
   localparam int ShiftLimit = (MAX_SHIFT < ResultCap) ? MAX_SHIFT : ResultCap;

   localparam int NumBits    = 32;
   localparam int BcdDigits  = 10;
   localparam int BcdW       = 4 * BcdDigits;
   localparam int CntW       = 6;

   // request codes
   localparam logic [2:0] REQ_INIT        = 3'd0;
   localparam logic [2:0] REQ_CLEAR       = 3'd1;
   localparam logic [2:0] REQ_CHAR        = 3'd2;
   localparam logic [2:0] REQ_CURSOR      = 3'd3;
   localparam logic [2:0] REQ_SHIFT_LEFT  = 3'd4;
   localparam logic [2:0] REQ_SHIFT_RIGHT = 3'd5;
   localparam logic [2:0] REQ_NUMBER      = 3'd6;

   // register indexes
   localparam logic [1:0] CSR_TWO_LINES   = 2'd0;
   localparam logic [1:0] CSR_LARGE_FONT  = 2'd1;
   localparam logic [1:0] CSR_DISPLAY_ON  = 2'd2;
   localparam logic [1:0] CSR_CURSOR_MODE = 2'd3;

   // bus bytes
   localparam logic [7:0] CMD_FUNC_SET    = 8'h30;
   localparam logic [7:0] CMD_DISP_CTRL   = 8'h08;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_FS,
      ST_INIT_DC,
      ST_INIT_CLR,
      ST_SINGLE,
      ST_SHIFT,
      ST_SIGN,
      ST_CONVERT,
      ST_DIGITS
   } state_type;

   // double-dabble correction: add 3 to every BCD digit of 5 or more
   function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] v);
      logic [BcdW-1:0] r;
      r = v;
      for (int i = 0; i < BcdDigits; i++) begin
         if (v[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = v[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/char_lcd_command_encoder.sv */
// An accepted request sets the state; each beat is then held in the output register.
// Init gives three beats, shift requests one beat per shift; beats go one per cycle
// unless the output stalls. A number gives a minus beat if negative, is converted
// bit-serially to BCD, skips up to 9 leading zero digits, then gives one beat per digit.
// A new request is taken once the previous one has issued its last beat.
// Synchronous reset: idle, no beat pending, config registers at their defaults.
// ----------------------------------------------------------------------------
// char_lcd_command_encoder
// Expands one display request into HD44780 register-select/byte bus writes.
// ----------------------------------------------------------------------------
module char_lcd_command_encoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic        req_row,
   input  logic [5:0]  req_column,
   input  logic [5:0]  req_shift_count,
   input  logic signed [31:0] req_number_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reg_select,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata
);
   import clcd_pkg::*;

   state_type state_ff, state_in;

   logic            two_lines_ff, large_font_ff, display_on_ff;
   logic [1:0]      cursor_mode_ff;

   logic [7:0]      byte_ff, byte_in;
   logic            rs_ff, rs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumBits-1:0] bin_ff, bin_in;
   logic [BcdW-1:0] bcd_ff, bcd_in;
   logic            started_ff, started_in;

   logic            rsp_valid_ff;
   logic            rsp_rs_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;

   logic            req_accept;
   logic            emit_valid, emit_rs, emit_last, emit_go;
   logic [7:0]      emit_byte;
   logic            digit_skip;
   logic [3:0]      digit;
   logic [CntW-1:0] shift_sat;
   logic [7:0]      fs_byte, dc_byte;
   logic [NumBits-1:0] num_mag;
   logic            num_neg;
   logic [BcdW-1:0] bcd_adj;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

   assign emit_go = emit_valid && (!rsp_valid_ff || !rsp_stall);

   assign fs_byte = CMD_FUNC_SET | {4'b0, two_lines_ff, large_font_ff, 2'b0};
   assign dc_byte = CMD_DISP_CTRL
                  | {5'b0, display_on_ff, (cursor_mode_ff != 2'd0), cursor_mode_ff[1]};

   assign shift_sat = (req_shift_count > CntW'(ShiftLimit)) ? CntW'(ShiftLimit)
                                                            : req_shift_count;
   assign num_neg   = req_number_value[NumBits-1];
   assign num_mag   = num_neg ? (NumBits'(0) - NumBits'(req_number_value))
                              : NumBits'(req_number_value);

   assign bcd_adj    = bcd_adjust(bcd_ff);
   assign digit      = bcd_ff[BcdW-1 -: 4];
   assign digit_skip = (state_ff == ST_DIGITS) && !started_ff && (digit == 4'd0)
                    && (cnt_ff != CntW'(BcdDigits - 1));

   // ---------------- config registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         two_lines_ff   <= 1'b1;
         large_font_ff  <= 1'b0;
         display_on_ff  <= 1'b1;
         cursor_mode_ff <= 2'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TWO_LINES:   two_lines_ff   <= csr_wdata[0];
            CSR_LARGE_FONT:  large_font_ff  <= csr_wdata[0];
            CSR_DISPLAY_ON:  display_on_ff  <= csr_wdata[0];
            CSR_CURSOR_MODE: cursor_mode_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_type) inside
                  REQ_INIT:                          state_in = ST_INIT_FS;
                  REQ_CLEAR, REQ_CHAR, REQ_CURSOR:   state_in = ST_SINGLE;
                  REQ_SHIFT_LEFT, REQ_SHIFT_RIGHT:
                     state_in = (shift_sat == '0) ? ST_IDLE : ST_SHIFT;
                  REQ_NUMBER: state_in = num_neg ? ST_SIGN : ST_CONVERT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT_FS:  if (emit_go) state_in = ST_INIT_DC;
         ST_INIT_DC:  if (emit_go) state_in = ST_INIT_CLR;
         ST_INIT_CLR: if (emit_go) state_in = ST_IDLE;
         ST_SINGLE:   if (emit_go) state_in = ST_IDLE;
         ST_SHIFT:    if (emit_go && cnt_ff == CntW'(1)) state_in = ST_IDLE;
         ST_SIGN:     if (emit_go) state_in = ST_CONVERT;
         ST_CONVERT:  if (cnt_ff == CntW'(NumBits - 1)) state_in = ST_DIGITS;
         ST_DIGITS: begin
            if (emit_go && cnt_ff == CntW'(BcdDigits - 1)) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- beat outputs ----------------
   always_comb begin
      emit_valid = 1'b0;
      emit_rs    = RS_CMD;
      emit_byte  = byte_ff;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_INIT_FS: begin
            emit_valid = 1'b1;
            emit_byte  = fs_byte;
         end
         ST_INIT_DC: begin
            emit_valid = 1'b1;
            emit_byte  = dc_byte;
         end
         ST_INIT_CLR: begin
            emit_valid = 1'b1;
            emit_byte  = CMD_CLEAR;
            emit_last  = 1'b1;
         end
         ST_SINGLE: begin
            emit_valid = 1'b1;
            emit_rs    = rs_ff;
            emit_last  = 1'b1;
         end
         ST_SHIFT: begin
            emit_valid = 1'b1;
            emit_last  = (cnt_ff == CntW'(1));
         end
         ST_SIGN: begin
            emit_valid = 1'b1;
            emit_rs    = RS_DATA;
            emit_byte  = CHAR_MINUS;
         end
         ST_CONVERT: ;
         ST_DIGITS: begin
            emit_valid = !digit_skip;
            emit_rs    = RS_DATA;
            emit_byte  = CHAR_ZERO | {4'b0, digit};
            emit_last  = (cnt_ff == CntW'(BcdDigits - 1));
         end
         default: ;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      cnt_in     = cnt_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      started_in = started_ff;
      if (req_accept) begin
         rs_in      = RS_CMD;
         cnt_in     = '0;
         bin_in     = num_mag;
         bcd_in     = '0;
         started_in = 1'b0;
         case (req_type) inside
            REQ_CLEAR:  byte_in = CMD_CLEAR;
            REQ_CHAR: begin
               byte_in = req_char_code;
               rs_in   = RS_DATA;
            end
            REQ_CURSOR: byte_in = CMD_SET_ADDR | {1'b0, req_row, req_column};
            REQ_SHIFT_LEFT, REQ_SHIFT_RIGHT: begin
               byte_in = (req_type == REQ_SHIFT_LEFT) ? CMD_SHIFT_LEFT : CMD_SHIFT_RIGHT;
               cnt_in  = shift_sat;
            end
            default: ;
         endcase
      end else if (state_ff == ST_SHIFT && emit_go) begin
         cnt_in = cnt_ff - CntW'(1);
      end else if (state_ff == ST_CONVERT) begin
         bcd_in = {bcd_adj[BcdW-2:0], bin_ff[NumBits-1]};
         bin_in = {bin_ff[NumBits-2:0], 1'b0};
         cnt_in = (cnt_ff == CntW'(NumBits - 1)) ? '0 : cnt_ff + CntW'(1);
      end else if (state_ff == ST_DIGITS && (emit_go || digit_skip)) begin
         bcd_in     = {bcd_ff[BcdW-5:0], 4'b0};
         cnt_in     = cnt_ff + CntW'(1);
         started_in = started_ff || emit_go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      rs_ff      <= rs_in;
      cnt_ff     <= cnt_in;
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      started_ff <= started_in;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_rs_ff   <= emit_rs;
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
      end
   end

   // ---------------- assertions ----------------
   a_number_entry: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == REQ_NUMBER)
      |=> (state_ff == ST_SIGN || state_ff == ST_CONVERT))
      else $error("number request did not enter sign or convert");

   a_convert_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && cnt_ff == CntW'(NumBits - 1))
      |=> (state_ff == ST_DIGITS && cnt_ff == '0))
      else $error("conversion did not hand over to digit output");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT)
      |-> (cnt_ff != '0 && cnt_ff <= CntW'(ShiftLimit)))
      else $error("shift count out of range");

   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (digit <= 4'd9))
      else $error("invalid BCD digit");

   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      (emit_go && state_ff == ST_DIGITS && emit_last) |=> (state_ff == ST_IDLE))
      else $error("last digit beat did not end the request");

endmodule
